FILE: src/tzpip_pkg.sv
// Package for the typed zone point-in-polygon core: item codes, status codes,
// field widths and the minimum zone size. No dependencies.
`default_nettype none

package tzpip_pkg;

	localparam int FUNC_W            = 2;
	localparam int KIND_W            = 4;
	localparam int STATUS_W          = 2;
	localparam int MIN_ZONE_VERTICES = 3;

	// item function codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_VTX_FULL   = 2'd1,
		ST_ZONE_FULL  = 2'd2,
		ST_ZONE_SHORT = 2'd3
	} status_t;

endpackage

`default_nettype wire

FILE: src/typed_zone_point_in_polygon_core.sv
// Typed zone point-in-polygon core: zone table, vertex store, query sequencer
// and one shared signed multiplier. Depends on tzpip_pkg.
`default_nettype none

// Geofence checker holding closed polygon zones, each with a 4-bit type code.
// For clear, append and unused-code items the result is in the output
// register on the cycle after the transfer. A query walks the zone table,
// reading and then checking each entry; a zone whose type matches adds a
// setup step and a wrap-up step, and for each edge an evaluation step, plus,
// for an edge that straddles the query row, two passes through the single
// multiplier and then the compare. A query stops at the first zone that
// contains the point. The block takes no new item while a query runs or
// while a result waits with the output side stalled.
module typed_zone_point_in_polygon_core #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_ZONES    = 16,
	parameter int COORD_BITS   = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [tzpip_pkg::FUNC_W-1:0]         func,
	input  wire logic signed [COORD_BITS-1:0]         coord_x,
	input  wire logic signed [COORD_BITS-1:0]         coord_y,
	input  wire logic [tzpip_pkg::KIND_W-1:0]         zone_kind,
	input  wire logic                                 zone_end,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      inside_res,
	output logic [tzpip_pkg::STATUS_W-1:0]            status
);

	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
	localparam int ZIDX_W = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int ZCNT_W = $clog2(MAX_ZONES + 1);
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} vtx_ent_t;

	typedef struct packed {
		logic [tzpip_pkg::KIND_W-1:0] kind;
		logic [VIDX_W-1:0]            start;
		logic [VCNT_W-1:0]            len;
	} zone_ent_t;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_ZRD   = 9'b000000010,
		S_ZCHK  = 9'b000000100,
		S_PREV  = 9'b000001000,
		S_EDGE  = 9'b000010000,
		S_MUL1  = 9'b000100000,
		S_MUL2  = 9'b001000000,
		S_CMP   = 9'b010000000,
		S_ZDONE = 9'b100000000
	} state_t;

	// control state
	state_t            state_q;
	logic              out_valid_q;
	logic [ZCNT_W-1:0] zcount_q;
	logic [VCNT_W-1:0] vcount_q;
	logic [VCNT_W-1:0] open_q;

	// storage
	vtx_ent_t  vtx_mem_q  [MAX_VERTICES];
	zone_ent_t zone_mem_q [MAX_ZONES];
	vtx_ent_t  vrd_q;
	zone_ent_t zrd_q;

	// query datapath
	logic signed [COORD_BITS-1:0] qx_q, qy_q;
	logic [tzpip_pkg::KIND_W-1:0] qkind_q;
	logic [ZCNT_W-1:0]            zi_q;
	logic [VIDX_W-1:0]            zstart_q;
	logic [VCNT_W-1:0]            zlen_q;
	logic [VIDX_W-1:0]            k_q;
	logic                         last_q;
	logic                         par_q;
	logic signed [COORD_BITS-1:0] xj_q, yj_q;
	logic signed [DIFF_W-1:0]     da_q, db_q, dc_q, dy_q;
	logic                         dy_pos_q;
	logic signed [PROD_W-1:0]     lhs_q, rhs_q;
	logic                         res_inside_q;
	logic [tzpip_pkg::STATUS_W-1:0] res_status_q;

	// handshake
	logic in_xfer;
	assign in_stall   = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_xfer    = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign inside_res = res_inside_q;
	assign status     = res_status_q;

	// append: store vertex, then close the open zone on zone end
	logic                  vfull_c;
	logic [VCNT_W-1:0]     vc_after_c;
	logic [VCNT_W-1:0]     zlen_new_c;
	logic                  zshort_c, ztfull_c, zone_add_c, vwr_en_c;
	logic [VCNT_W-1:0]     vcount_new_c, open_new_c;
	tzpip_pkg::status_t    app_status_c;

	always_comb begin
		vfull_c      = (vcount_q == VCNT_W'(MAX_VERTICES));
		vc_after_c   = vfull_c ? vcount_q : vcount_q + VCNT_W'(1);
		zlen_new_c   = vc_after_c - open_q;
		zshort_c     = zlen_new_c < VCNT_W'(tzpip_pkg::MIN_ZONE_VERTICES);
		ztfull_c     = (zcount_q == ZCNT_W'(MAX_ZONES));
		zone_add_c   = zone_end && !zshort_c && !ztfull_c;
		vwr_en_c     = in_xfer && (tzpip_pkg::func_t'(func) == tzpip_pkg::FUNC_APPEND)
			&& !vfull_c;
		vcount_new_c = (zone_end && !zone_add_c) ? open_q : vc_after_c;
		open_new_c   = zone_end ? vcount_new_c : open_q;
		if (vfull_c) begin
			app_status_c = tzpip_pkg::ST_VTX_FULL;
		end else if (!zone_end) begin
			app_status_c = tzpip_pkg::ST_OK;
		end else if (zshort_c) begin
			app_status_c = tzpip_pkg::ST_ZONE_SHORT;
		end else if (ztfull_c) begin
			app_status_c = tzpip_pkg::ST_ZONE_FULL;
		end else begin
			app_status_c = tzpip_pkg::ST_OK;
		end
	end

	// zone checks and edge evaluation on the entries just read
	logic zi_lt_c, kind_match_c, cross_c, last_c, toggle_c;
	always_comb begin
		zi_lt_c      = zi_q < zcount_q;
		kind_match_c = (zrd_q.kind == qkind_q);
		cross_c      = (vrd_q.y > qy_q) != (yj_q > qy_q);
		last_c       = (VCNT_W'(k_q) + VCNT_W'(1)) == zlen_q;
		toggle_c     = dy_pos_q ? (lhs_q < rhs_q) : (rhs_q < lhs_q);
	end

	// result register load
	logic res_load_c;
	always_comb begin
		case (state_q)
			S_IDLE:  res_load_c = in_xfer
				&& (tzpip_pkg::func_t'(func) != tzpip_pkg::FUNC_QUERY);
			S_ZRD:   res_load_c = !zi_lt_c;
			S_ZDONE: res_load_c = par_q;
			default: res_load_c = 1'b0;
		endcase
	end

	// vertex read address
	logic              vrd_en_c;
	logic [VCNT_W:0]   vrd_sum_c;
	always_comb begin
		vrd_en_c  = 1'b0;
		vrd_sum_c = '0;
		case (state_q)
			S_ZCHK: begin
				vrd_en_c  = kind_match_c;
				vrd_sum_c = (VCNT_W+1)'(zrd_q.start) + (VCNT_W+1)'(zrd_q.len)
					- (VCNT_W+1)'(1);
			end
			S_PREV: begin
				vrd_en_c  = 1'b1;
				vrd_sum_c = (VCNT_W+1)'(zstart_q);
			end
			S_EDGE: begin
				vrd_en_c  = !last_c;
				vrd_sum_c = (VCNT_W+1)'(zstart_q) + (VCNT_W+1)'(k_q) + (VCNT_W+1)'(1);
			end
			default: begin
				vrd_en_c  = 1'b0;
				vrd_sum_c = '0;
			end
		endcase
	end

	// shared multiplier
	logic signed [DIFF_W-1:0] mul_a_c, mul_b_c;
	logic signed [PROD_W-1:0] prod_c;
	assign mul_a_c = (state_q == S_MUL2) ? db_q : da_q;
	assign mul_b_c = (state_q == S_MUL2) ? dc_q : dy_q;
	assign prod_c  = mul_a_c * mul_b_c;

	// vertex store
	always_ff @(posedge clk) begin
		if (vwr_en_c) begin
			vtx_mem_q[vcount_q[VIDX_W-1:0]] <= '{x: coord_x, y: coord_y};
		end
		if (vrd_en_c) begin
			vrd_q <= vtx_mem_q[vrd_sum_c[VIDX_W-1:0]];
		end
	end

	// zone table
	always_ff @(posedge clk) begin
		if (in_xfer && (tzpip_pkg::func_t'(func) == tzpip_pkg::FUNC_APPEND) && zone_add_c)
		begin
			zone_mem_q[zcount_q[ZIDX_W-1:0]] <= '{kind: zone_kind,
				start: open_q[VIDX_W-1:0], len: zlen_new_c};
		end
		if ((state_q == S_ZRD) && zi_lt_c) begin
			zrd_q <= zone_mem_q[zi_q[ZIDX_W-1:0]];
		end
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			zcount_q    <= '0;
			vcount_q    <= '0;
			open_q      <= '0;
		end else begin
			out_valid_q <= res_load_c || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						case (tzpip_pkg::func_t'(func))
							tzpip_pkg::FUNC_CLEAR: begin
								zcount_q    <= '0;
								vcount_q    <= '0;
								open_q      <= '0;
							end
							tzpip_pkg::FUNC_APPEND: begin
								vcount_q    <= vcount_new_c;
								open_q      <= open_new_c;
								if (zone_add_c) begin
									zcount_q <= zcount_q + ZCNT_W'(1);
								end
							end
							tzpip_pkg::FUNC_QUERY: begin
								state_q <= S_ZRD;
							end
							default: begin
							end
						endcase
					end
				end
				S_ZRD:   state_q <= zi_lt_c ? S_ZCHK : S_IDLE;
				S_ZCHK:  state_q <= kind_match_c ? S_PREV : S_ZRD;
				S_PREV:  state_q <= S_EDGE;
				S_EDGE: begin
					if (cross_c) begin
						state_q <= S_MUL1;
					end else if (last_c) begin
						state_q <= S_ZDONE;
					end else begin
						state_q <= S_EDGE;
					end
				end
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_CMP;
				S_CMP:   state_q <= last_q ? S_ZDONE : S_EDGE;
				S_ZDONE: state_q <= par_q ? S_IDLE : S_ZRD;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// query datapath and result register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					qx_q         <= coord_x;
					qy_q         <= coord_y;
					qkind_q      <= zone_kind;
					zi_q         <= '0;
					res_inside_q <= 1'b0;
					res_status_q <= (tzpip_pkg::func_t'(func) == tzpip_pkg::FUNC_APPEND)
						? app_status_c : tzpip_pkg::ST_OK;
				end
			end
			S_ZCHK: begin
				zstart_q <= zrd_q.start;
				zlen_q   <= zrd_q.len;
				if (!kind_match_c) begin
					zi_q <= zi_q + ZCNT_W'(1);
				end
			end
			S_PREV: begin
				xj_q  <= vrd_q.x;
				yj_q  <= vrd_q.y;
				k_q   <= '0;
				par_q <= 1'b0;
			end
			S_EDGE: begin
				da_q     <= $signed({qx_q[COORD_BITS-1], qx_q})
					- $signed({vrd_q.x[COORD_BITS-1], vrd_q.x});
				db_q     <= $signed({xj_q[COORD_BITS-1], xj_q})
					- $signed({vrd_q.x[COORD_BITS-1], vrd_q.x});
				dc_q     <= $signed({qy_q[COORD_BITS-1], qy_q})
					- $signed({vrd_q.y[COORD_BITS-1], vrd_q.y});
				dy_q     <= $signed({yj_q[COORD_BITS-1], yj_q})
					- $signed({vrd_q.y[COORD_BITS-1], vrd_q.y});
				dy_pos_q <= yj_q > vrd_q.y;
				last_q   <= last_c;
				xj_q     <= vrd_q.x;
				yj_q     <= vrd_q.y;
				if (!last_c) begin
					k_q <= k_q + VIDX_W'(1);
				end
			end
			S_MUL1: lhs_q <= prod_c;
			S_MUL2: rhs_q <= prod_c;
			S_CMP: begin
				if (toggle_c) begin
					par_q <= ~par_q;
				end
			end
			S_ZDONE: begin
				if (par_q) begin
					res_inside_q <= 1'b1;
				end else begin
					zi_q <= zi_q + ZCNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// checks on bookkeeping and sequencing
	a_open_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= vcount_q)
		else $error("open zone start beyond vertex count");

	a_zone_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		zcount_q <= ZCNT_W'(MAX_ZONES))
		else $error("zone count beyond table size");

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !out_valid_q)
		else $error("result pending while a query runs");

	a_edge_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EDGE) |-> (VCNT_W'(k_q) < zlen_q))
		else $error("edge index past zone length");

	a_inside_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_inside_q) |-> (res_status_q == tzpip_pkg::ST_OK))
		else $error("inside result with non-ok status");

endmodule

`default_nettype wire
